@@ hw/rtl/median_lux_brightness_selector_defines.svh @@
// Assertion macros shared by the median lux brightness selector RTL.
`ifndef MEDIAN_LUX_BRIGHTNESS_SELECTOR_DEFINES_SVH
`define MEDIAN_LUX_BRIGHTNESS_SELECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MLBS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("Same-cycle assertion failed.");

// The consequent must hold in the cycle after the antecedent.
`define MLBS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("Next-cycle assertion failed.");

`endif

@@ hw/rtl/mlbs_pkg.sv @@
// Package with constants, codes and reset values for the median lux brightness selector.
package mlbs_pkg;

    localparam int WINDOW_SIZE_DEFAULT = 5;

    localparam int LUX_W   = 16;
    localparam int LEVEL_W = 8;
    localparam int MODE_W  = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_PRESENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAY_THRESHOLD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUSK_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DAY_LEVEL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUSK_LEVEL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NIGHT_LEVEL    = 3'd5;

    localparam logic [MODE_W-1:0] MODE_DAY   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DUSK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NIGHT = 2'd2;

    localparam logic               SENSOR_PRESENT_RST = 1'b1;
    localparam logic [LUX_W-1:0]   DAY_THRESHOLD_RST  = 16'd100;
    localparam logic [LUX_W-1:0]   DUSK_THRESHOLD_RST = 16'd10;
    localparam logic [LEVEL_W-1:0] DAY_LEVEL_RST      = 8'd255;
    localparam logic [LEVEL_W-1:0] DUSK_LEVEL_RST     = 8'd128;
    localparam logic [LEVEL_W-1:0] NIGHT_LEVEL_RST    = 8'd32;

endpackage

@@ hw/rtl/median_lux_brightness_selector.sv @@
// Top level: running median of light samples, classified into a backlight mode and level.
//
// Channel | Direction | Handshake          | Payload
// s_      | input     | s_valid / s_ready  | s_lux_sample
// m_      | output    | m_valid / m_ready  | m_median_lux, m_light_mode, m_backlight_level,
//         |           |                    | m_mode_changed
// cfg_    | input     | cfg_wr_en          | cfg_index, cfg_data
//
// One transaction is accepted per cycle unless one is pending and the result register is stalled.
// The accepting edge writes the sample into the window registers; once the result register is
// free, the median is taken by rank counting over all window entries and classified into it.
// Reset is synchronous and active low; it clears the window and the mode and reloads the
// configuration with its reset values.
// When the result register is held by a stalled consumer, one further transaction is taken.
`include "median_lux_brightness_selector_defines.svh"

module median_lux_brightness_selector #(
    parameter int WINDOW_SIZE = mlbs_pkg::WINDOW_SIZE_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [mlbs_pkg::LUX_W-1:0]       s_lux_sample,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [mlbs_pkg::LUX_W-1:0]       m_median_lux,
    output logic [mlbs_pkg::MODE_W-1:0]      m_light_mode,
    output logic [mlbs_pkg::LEVEL_W-1:0]     m_backlight_level,
    output logic                             m_mode_changed,

    input  logic                             cfg_wr_en,
    input  logic [mlbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mlbs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import mlbs_pkg::*;

    localparam int PTR_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam logic [CNT_W-1:0] RANK_WANT = CNT_W'(WINDOW_SIZE / 2);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(WINDOW_SIZE - 1);

    logic               sensor_present_reg;
    logic [LUX_W-1:0]   day_threshold_reg;
    logic [LUX_W-1:0]   dusk_threshold_reg;
    logic [LEVEL_W-1:0] day_level_reg;
    logic [LEVEL_W-1:0] dusk_level_reg;
    logic [LEVEL_W-1:0] night_level_reg;

    logic [LUX_W-1:0]   window_reg [WINDOW_SIZE];
    logic [PTR_W-1:0]   wr_pos_reg;
    logic [PTR_W-1:0]   wr_pos_next;
    logic               pend_valid_reg;

    logic               m_valid_reg;
    logic [LUX_W-1:0]   median_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [MODE_W-1:0]  mode_next;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    logic               changed_reg;

    logic [LUX_W-1:0]   median_next;
    logic               s_accept;
    logic               out_free;
    logic               res_load;

    assign out_free = !m_valid_reg || m_ready;
    assign res_load = pend_valid_reg && out_free;
    assign s_ready  = !pend_valid_reg || out_free;
    assign s_accept = s_valid && s_ready;

    assign wr_pos_next = (wr_pos_reg == PTR_LAST) ? '0 : wr_pos_reg + 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sensor_present_reg <= SENSOR_PRESENT_RST;
            day_threshold_reg  <= DAY_THRESHOLD_RST;
            dusk_threshold_reg <= DUSK_THRESHOLD_RST;
            day_level_reg      <= DAY_LEVEL_RST;
            dusk_level_reg     <= DUSK_LEVEL_RST;
            night_level_reg    <= NIGHT_LEVEL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SENSOR_PRESENT: sensor_present_reg <= cfg_data[0];
                REG_DAY_THRESHOLD:  day_threshold_reg  <= cfg_data[LUX_W-1:0];
                REG_DUSK_THRESHOLD: dusk_threshold_reg <= cfg_data[LUX_W-1:0];
                REG_DAY_LEVEL:      day_level_reg      <= cfg_data[LEVEL_W-1:0];
                REG_DUSK_LEVEL:     dusk_level_reg     <= cfg_data[LEVEL_W-1:0];
                REG_NIGHT_LEVEL:    night_level_reg    <= cfg_data[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sample window; an absent sensor leaves it untouched.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_SIZE; i++) begin
                window_reg[i] <= '0;
            end
            wr_pos_reg     <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (s_accept && sensor_present_reg) begin
                window_reg[wr_pos_reg] <= s_lux_sample;
                wr_pos_reg             <= wr_pos_next;
            end
            if (s_accept) begin
                pend_valid_reg <= 1'b1;
            end else if (res_load) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // Median by rank counting: an entry is the median when the wanted rank lies
    // within its span of equal values. All matching entries hold the same value.
    always_comb begin
        logic [CNT_W-1:0] below;
        logic [CNT_W-1:0] upto;
        median_next = '0;
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            below = '0;
            upto  = '0;
            for (int j = 0; j < WINDOW_SIZE; j++) begin
                if (window_reg[j] < window_reg[i]) begin
                    below = below + 1'b1;
                end
                if (window_reg[j] <= window_reg[i]) begin
                    upto = upto + 1'b1;
                end
            end
            if ((below <= RANK_WANT) && (RANK_WANT < upto)) begin
                median_next = median_next | window_reg[i];
            end
        end
    end

    always_comb begin
        if (!sensor_present_reg) begin
            mode_next = MODE_DAY;
        end else if (median_next >= day_threshold_reg) begin
            mode_next = MODE_DAY;
        end else if (median_next >= dusk_threshold_reg) begin
            mode_next = MODE_DUSK;
        end else begin
            mode_next = MODE_NIGHT;
        end
    end

    always_comb begin
        case (mode_next)
            MODE_DAY:  level_next = day_level_reg;
            MODE_DUSK: level_next = dusk_level_reg;
            default:   level_next = night_level_reg;
        endcase
    end

    // Result register and the mode carried from one transaction to the next.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            mode_reg    <= MODE_DAY;
        end else begin
            if (res_load) begin
                m_valid_reg <= 1'b1;
                mode_reg    <= mode_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            median_reg  <= median_next;
            level_reg   <= level_next;
            changed_reg <= (mode_next != mode_reg);
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_median_lux      = median_reg;
    assign m_light_mode      = mode_reg;
    assign m_backlight_level = level_reg;
    assign m_mode_changed    = changed_reg;

    `MLBS_ASSERT_SAME(a_no_take_when_full, pend_valid_reg && m_valid && !m_ready, !s_ready)
    `MLBS_ASSERT_SAME(a_wr_pos_in_range, 1'b1, wr_pos_reg <= PTR_LAST)
    `MLBS_ASSERT_NEXT(a_pending_moves_on, pend_valid_reg && out_free, m_valid)
    `MLBS_ASSERT_NEXT(a_change_flag, res_load, m_mode_changed == (m_light_mode != $past(mode_reg)))

endmodule

@@ verif/median_lux_brightness_selector_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the median lux brightness selector: directed table, then random phases.
module median_lux_brightness_selector_tb;
    import mlbs_pkg::*;

    localparam int WIN           = WINDOW_SIZE_DEFAULT;
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_ITEMS   = 25;
    localparam int SETTLE_CYCLES = 4;
    localparam int DIRECTED_ROWS = 31;

    typedef struct packed {
        logic [LUX_W-1:0]   median;
        logic [MODE_W-1:0]  mode;
        logic [LEVEL_W-1:0] level;
        logic               changed;
    } lux_result_t;

    typedef enum logic {ROW_LUX, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
        logic                  typed;
        lux_result_t           result;
    } stim_row_t;

    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_LUX, '0, 16'd0,     1'b1, '{16'd0,     MODE_NIGHT, 8'd32,  1'b1}},
        '{ROW_LUX, '0, 16'd65535, 1'b1, '{16'd0,     MODE_NIGHT, 8'd32,  1'b0}},
        '{ROW_LUX, '0, 16'd65535, 1'b0, '0},
        '{ROW_LUX, '0, 16'd65535, 1'b1, '{16'd65535, MODE_DAY,   8'd255, 1'b1}},
        '{ROW_LUX, '0, 16'd50,    1'b0, '0},
        '{ROW_LUX, '0, 16'd50,    1'b0, '0},
        '{ROW_LUX, '0, 16'd7,     1'b0, '0},
        '{ROW_LUX, '0, 16'd7,     1'b0, '0},
        '{ROW_CFG, REG_SENSOR_PRESENT, 16'd0, 1'b0, '0},
        '{ROW_LUX, '0, 16'd12345, 1'b0, '0},
        '{ROW_LUX, '0, 16'd0,     1'b0, '0},
        '{ROW_CFG, REG_SENSOR_PRESENT, 16'd1,    1'b0, '0},
        '{ROW_CFG, REG_DAY_THRESHOLD,  16'd1000, 1'b0, '0},
        '{ROW_CFG, REG_DUSK_THRESHOLD, 16'd2000, 1'b0, '0},
        '{ROW_LUX, '0, 16'd1500,  1'b0, '0},
        '{ROW_LUX, '0, 16'd1500,  1'b0, '0},
        '{ROW_LUX, '0, 16'd1500,  1'b0, '0},
        '{ROW_LUX, '0, 16'd999,   1'b0, '0},
        '{ROW_LUX, '0, 16'd999,   1'b0, '0},
        '{ROW_LUX, '0, 16'd999,   1'b0, '0},
        '{ROW_CFG, REG_DAY_THRESHOLD,  16'd0,     1'b0, '0},
        '{ROW_CFG, REG_DAY_LEVEL,      16'd0,     1'b0, '0},
        '{ROW_LUX, '0, 16'd0,     1'b0, '0},
        '{ROW_CFG, REG_DAY_THRESHOLD,  16'd65535, 1'b0, '0},
        '{ROW_CFG, REG_DUSK_THRESHOLD, 16'd0,     1'b0, '0},
        '{ROW_CFG, REG_DUSK_LEVEL,     16'd255,   1'b0, '0},
        '{ROW_CFG, REG_NIGHT_LEVEL,    16'd0,     1'b0, '0},
        '{ROW_LUX, '0, 16'd65535, 1'b0, '0},
        '{ROW_LUX, '0, 16'd65535, 1'b0, '0},
        '{ROW_LUX, '0, 16'd65535, 1'b0, '0},
        '{ROW_LUX, '0, 16'd65535, 1'b0, '0}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [LUX_W-1:0]      s_lux_sample = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [LUX_W-1:0]      m_median_lux;
    logic [MODE_W-1:0]     m_light_mode;
    logic [LEVEL_W-1:0]    m_backlight_level;
    logic                  m_mode_changed;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [LUX_W-1:0]   lux_window [WIN];
    int unsigned        wr_slot;
    logic [MODE_W-1:0]  mode_now;
    logic               cfg_sensor;
    logic [LUX_W-1:0]   cfg_day_thr;
    logic [LUX_W-1:0]   cfg_dusk_thr;
    logic [LEVEL_W-1:0] cfg_day_lvl;
    logic [LEVEL_W-1:0] cfg_dusk_lvl;
    logic [LEVEL_W-1:0] cfg_night_lvl;

    lux_result_t pending_results [$];
    int unsigned fail_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    median_lux_brightness_selector dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_lux_sample      (s_lux_sample),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_median_lux      (m_median_lux),
        .m_light_mode      (m_light_mode),
        .m_backlight_level (m_backlight_level),
        .m_mode_changed    (m_mode_changed),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [LUX_W-1:0] mid_rank_lux();
        logic [LUX_W-1:0] sorted [WIN];
        logic [LUX_W-1:0] key;
        int j;
        for (int i = 0; i < WIN; i++) sorted[i] = lux_window[i];
        for (int i = 1; i < WIN; i++) begin
            key = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > key) begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = key;
        end
        return sorted[WIN / 2];
    endfunction

    function automatic lux_result_t classify_sample(input logic [LUX_W-1:0] lux);
        lux_result_t r;
        logic [MODE_W-1:0] next_mode;
        if (cfg_sensor) begin
            lux_window[wr_slot] = lux;
            wr_slot = (wr_slot + 1) % WIN;
        end
        r.median = mid_rank_lux();
        if (!cfg_sensor || r.median >= cfg_day_thr) next_mode = MODE_DAY;
        else if (r.median >= cfg_dusk_thr) next_mode = MODE_DUSK;
        else next_mode = MODE_NIGHT;
        r.changed = (next_mode != mode_now);
        r.mode = next_mode;
        mode_now = next_mode;
        case (next_mode)
            MODE_DAY:  r.level = cfg_day_lvl;
            MODE_DUSK: r.level = cfg_dusk_lvl;
            default:   r.level = cfg_night_lvl;
        endcase
        return r;
    endfunction

    function automatic logic [LUX_W-1:0] pick_threshold(input int unsigned span);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return LUX_W'($urandom_range(0, span));
        endcase
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return LEVEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge aclk);
        case (idx)
            REG_SENSOR_PRESENT: cfg_sensor    = val[0];
            REG_DAY_THRESHOLD:  cfg_day_thr   = val[LUX_W-1:0];
            REG_DUSK_THRESHOLD: cfg_dusk_thr  = val[LUX_W-1:0];
            REG_DAY_LEVEL:      cfg_day_lvl   = val[LEVEL_W-1:0];
            REG_DUSK_LEVEL:     cfg_dusk_lvl  = val[LEVEL_W-1:0];
            REG_NIGHT_LEVEL:    cfg_night_lvl = val[LEVEL_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Holds the sender off until every outstanding result has been taken.
    task automatic quiesce();
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic push_lux(input logic [LUX_W-1:0] lux, input logic typed,
                            input lux_result_t given);
        lux_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_lux_sample = lux;
        do @(posedge aclk); while (!s_ready);
        predicted = classify_sample(lux);
        pending_results.push_back(typed ? given : predicted);
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        lux_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("Result transaction arrived with nothing expected.");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_median_lux !== want.median) begin
                    $error("median_lux: expected %0d, actual %0d", want.median, m_median_lux);
                    fail_count++;
                end
                if (m_light_mode !== want.mode) begin
                    $error("light_mode: expected %0d, actual %0d", want.mode, m_light_mode);
                    fail_count++;
                end
                if (m_backlight_level !== want.level) begin
                    $error("backlight_level: expected %0d, actual %0d",
                           want.level, m_backlight_level);
                    fail_count++;
                end
                if (m_mode_changed !== want.changed) begin
                    $error("mode_changed: expected %0d, actual %0d",
                           want.changed, m_mode_changed);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("** median_lux_brightness_selector: FAILED **");
        $finish;
    end

    initial begin
        stim_row_t        row;
        int unsigned      phase_span;
        logic [LUX_W-1:0] thr_a;
        logic [LUX_W-1:0] thr_b;
        logic [LUX_W-1:0] lux;
        cfg_sensor    = SENSOR_PRESENT_RST;
        cfg_day_thr   = DAY_THRESHOLD_RST;
        cfg_dusk_thr  = DUSK_THRESHOLD_RST;
        cfg_day_lvl   = DAY_LEVEL_RST;
        cfg_dusk_lvl  = DUSK_LEVEL_RST;
        cfg_night_lvl = NIGHT_LEVEL_RST;
        for (int i = 0; i < WIN; i++) lux_window[i] = '0;
        wr_slot  = 0;
        mode_now = MODE_DAY;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = DIRECTED[i];
            if (row.kind == ROW_CFG) begin
                quiesce();
                write_reg(row.index, row.value);
            end else begin
                push_lux(row.value[LUX_W-1:0], row.typed, row.result);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            quiesce();
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            case ($urandom_range(0, 2))
                0:       phase_span = 255;
                1:       phase_span = 4095;
                default: phase_span = 65535;
            endcase
            thr_a = pick_threshold(phase_span);
            thr_b = pick_threshold(phase_span);
            // Thresholds are mostly kept in order, with the odd crossed pair left in.
            if (thr_b > thr_a && $urandom_range(0, 3) != 0) begin
                thr_a = thr_a ^ thr_b;
                thr_b = thr_a ^ thr_b;
                thr_a = thr_a ^ thr_b;
            end
            write_reg(REG_SENSOR_PRESENT, CFG_DATA_W'($urandom_range(0, 5) != 0));
            write_reg(REG_DAY_THRESHOLD, thr_a);
            write_reg(REG_DUSK_THRESHOLD, thr_b);
            write_reg(REG_DAY_LEVEL, CFG_DATA_W'(pick_level()));
            write_reg(REG_DUSK_LEVEL, CFG_DATA_W'(pick_level()));
            write_reg(REG_NIGHT_LEVEL, CFG_DATA_W'(pick_level()));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 39) == 0) quiesce();
                if ($urandom_range(0, 7) == 0) lux = LUX_W'($urandom_range(0, 65535));
                else lux = LUX_W'($urandom_range(0, phase_span));
                push_lux(lux, 1'b0, '0);
            end
        end

        quiesce();
        if (fail_count == 0) begin
            $display("** median_lux_brightness_selector: PASSED **");
        end else begin
            $display("** median_lux_brightness_selector: FAILED **");
        end
        $finish;
    end

endmodule
